// ----- hdl/iee_pkg.sv -----
package iee_pkg;

    localparam int MAX_DEPTH   = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int CHAR_W      = 8;
    localparam int OUT_W       = 32;
    localparam int ERR_W       = 2;

    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE,
        ERR_DIV0,
        ERR_BADCH,
        ERR_DEEP
    } t_err;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_MUL,
        OP_DIV
    } t_op;

    typedef enum logic [1:0] {
        K_ADD,
        K_SUB,
        K_MUL,
        K_DIV
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FEED,
        S_WAIT,
        S_APPLY,
        S_LOAD,
        S_FINAL,
        S_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic is_div;
    } t_alu_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_alu_rsp;

endpackage

// ----- hdl/iee_if.sv -----
interface iee_in_if;
    logic                           valid;
    logic                           ready;
    logic [iee_pkg::CHAR_W-1:0]     character;
    logic                           last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

interface iee_out_if;
    logic                           valid;
    logic                           ready;
    logic signed [iee_pkg::OUT_W-1:0] value;
    logic [iee_pkg::ERR_W-1:0]      error_code;

    modport source (output valid, output value, output error_code, input ready);
    modport sink   (input valid, input value, input error_code, output ready);
endinterface

// ----- hdl/iee_alu.sv -----
module iee_alu #(
    parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  iee_pkg::t_alu_req       i_req,
    input  logic [VALUE_WIDTH-1:0]  i_a,
    input  logic [VALUE_WIDTH-1:0]  i_b,
    output iee_pkg::t_alu_rsp       o_rsp,
    output logic [VALUE_WIDTH-1:0]  o_result
);

    localparam int VW    = VALUE_WIDTH;
    localparam int CNT_W = $clog2(VW);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_is_div, n_is_div;
    logic             r_neg, n_neg;
    logic [VW-1:0]    r_acc, n_acc;
    logic [VW-1:0]    r_x, n_x;
    logic [VW-1:0]    r_y, n_y;

    logic [VW:0]      add_a, add_b, add_sum;
    logic             fits;
    logic [VW-1:0]    a_mag, b_mag;

    always_comb begin
        a_mag   = i_a[VW-1] ? (VW'(0) - i_a) : i_a;
        b_mag   = i_b[VW-1] ? (VW'(0) - i_b) : i_b;
        add_a   = r_is_div ? {r_acc, r_x[VW-1]} : {1'b0, r_acc};
        add_b   = r_is_div ? ~{1'b0, r_y} : {1'b0, r_x};
        add_sum = add_a + add_b + (VW+1)'(r_is_div);
        fits    = ~add_sum[VW];
    end

    always_comb begin
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_cnt    = r_cnt;
        n_is_div = r_is_div;
        n_neg    = r_neg;
        n_acc    = r_acc;
        n_x      = r_x;
        n_y      = r_y;
        if (i_req.start) begin
            n_busy   = 1'b1;
            n_cnt    = '0;
            n_is_div = i_req.is_div;
            n_neg    = i_a[VW-1] ^ i_b[VW-1];
            n_acc    = '0;
            n_x      = i_req.is_div ? a_mag : i_a;
            n_y      = i_req.is_div ? b_mag : i_b;
        end else if (r_busy) begin
            if (r_is_div) begin
                n_acc = fits ? add_sum[VW-1:0] : {r_acc[VW-2:0], r_x[VW-1]};
                n_x   = {r_x[VW-2:0], fits};
            end else begin
                if (r_y[0]) begin
                    n_acc = add_sum[VW-1:0];
                end
                n_x = {r_x[VW-2:0], 1'b0};
                n_y = {1'b0, r_y[VW-1:1]};
            end
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(VW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt    <= n_cnt;
        r_is_div <= n_is_div;
        r_neg    <= n_neg;
        r_acc    <= n_acc;
        r_x      <= n_x;
        r_y      <= n_y;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_result   = r_is_div ? (r_neg ? (VW'(0) - r_x) : r_x) : r_acc;

endmodule

// ----- hdl/infix_expression_evaluator.sv -----
// Channel   Role    Payload
// i_in      sink    character[7:0], last
// o_out     source  value[31:0] signed, error_code[1:0]
//
// A digit, ( or unmatched ) passes S_IDLE and S_DECODE; an operator also passes S_FEED and S_APPLY, a closing ) S_LOAD.
// After a pending * or / the shared shift-add/subtract unit is started in S_FEED,
// and S_WAIT holds until it reports done.
// Unless an error is set, the final character closes each open level in turn.
// Synchronous active-low reset clears the control state and level zero.
// A waiting result sits in the output register while the next item is taken.
module infix_expression_evaluator #(
    parameter int MAX_DEPTH   = iee_pkg::MAX_DEPTH,
    parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    iee_in_if.sink    i_in,
    iee_out_if.source o_out
);

    localparam int VW      = VALUE_WIDTH;
    localparam int LVL_W   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int FRAME_W = 3 * VW + 3;
    localparam int OUT_W   = iee_pkg::OUT_W;
    localparam int EXT_W   = (VW > OUT_W) ? VW : OUT_W;

    iee_pkg::t_state r_state, n_state;
    logic [iee_pkg::CHAR_W-1:0] r_char, n_char;
    logic             r_last, n_last;
    logic [LVL_W-1:0] r_lv, n_lv;
    logic             r_ignore, n_ignore;
    iee_pkg::t_err    r_err, n_err;
    logic [VW-1:0]    r_sum, n_sum;
    logic [VW-1:0]    r_term, n_term;
    logic [VW-1:0]    r_cur, n_cur;
    logic             r_neg, n_neg;
    iee_pkg::t_op     r_op, n_op;
    iee_pkg::t_kind   r_kind, n_kind;
    logic             r_closing, n_closing;
    logic [VW-1:0]    r_v, n_v;
    logic [VW-1:0]    r_res, n_res;

    logic             r_out_valid, n_out_valid;
    logic [OUT_W-1:0] r_out_value, n_out_value;
    iee_pkg::t_err    r_out_err, n_out_err;

    logic [FRAME_W-1:0] mem [MAX_DEPTH];
    logic [FRAME_W-1:0] r_rdata;
    logic               mem_we;

    iee_pkg::t_alu_req  alu_req;
    iee_pkg::t_alu_rsp  alu_rsp;
    logic [VW-1:0]      alu_result;

    logic             is_digit, is_lp, is_rp, is_op, skip, lv_full, lv_zero;
    logic             div_zero, out_load;
    iee_pkg::t_kind   char_kind;
    iee_pkg::t_state  st_done;
    logic [iee_pkg::CHAR_W-1:0] digit_raw;
    logic [VW-1:0]    cur_x10, applied_sum;
    logic [EXT_W-1:0] res_ext;

    iee_alu #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_a     (r_term),
        .i_b     (r_cur),
        .o_rsp   (alu_rsp),
        .o_result(alu_result)
    );

    always_comb begin
        is_digit  = (r_char >= iee_pkg::CH_ZERO) && (r_char <= iee_pkg::CH_NINE);
        is_lp     = (r_char == iee_pkg::CH_LPAREN);
        is_rp     = (r_char == iee_pkg::CH_RPAREN);
        is_op     = (r_char == iee_pkg::CH_PLUS) || (r_char == iee_pkg::CH_MINUS) ||
                    (r_char == iee_pkg::CH_STAR) || (r_char == iee_pkg::CH_SLASH);
        case (r_char)
            iee_pkg::CH_PLUS:  char_kind = iee_pkg::K_ADD;
            iee_pkg::CH_MINUS: char_kind = iee_pkg::K_SUB;
            iee_pkg::CH_STAR:  char_kind = iee_pkg::K_MUL;
            default:           char_kind = iee_pkg::K_DIV;
        endcase
        skip        = (r_err != iee_pkg::ERR_NONE) || r_ignore;
        lv_full     = (r_lv == LVL_W'(MAX_DEPTH - 1));
        lv_zero     = (r_lv == '0);
        div_zero    = (r_op == iee_pkg::OP_DIV) && (r_cur == '0);
        st_done     = r_last ? iee_pkg::S_FINAL : iee_pkg::S_IDLE;
        digit_raw   = r_char - iee_pkg::CH_ZERO;
        cur_x10     = (r_cur << 3) + (r_cur << 1) + VW'(digit_raw[3:0]);
        applied_sum = r_neg ? (r_sum - r_v) : (r_sum + r_v);
        res_ext     = EXT_W'(r_res);
        out_load    = (r_state == iee_pkg::S_OUT) && (!r_out_valid || o_out.ready);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            iee_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_state = iee_pkg::S_DECODE;
                end
            end
            iee_pkg::S_DECODE: begin
                if (skip) begin
                    n_state = st_done;
                end else if (is_op || (is_rp && !lv_zero)) begin
                    n_state = iee_pkg::S_FEED;
                end else begin
                    n_state = st_done;
                end
            end
            iee_pkg::S_FEED: begin
                if (div_zero) begin
                    n_state = st_done;
                end else if (r_op == iee_pkg::OP_NONE) begin
                    n_state = iee_pkg::S_APPLY;
                end else begin
                    n_state = iee_pkg::S_WAIT;
                end
            end
            iee_pkg::S_WAIT: begin
                if (alu_rsp.done) begin
                    n_state = iee_pkg::S_APPLY;
                end
            end
            iee_pkg::S_APPLY: begin
                if (!r_closing) begin
                    n_state = st_done;
                end else if (lv_zero) begin
                    n_state = iee_pkg::S_OUT;
                end else begin
                    n_state = iee_pkg::S_LOAD;
                end
            end
            iee_pkg::S_LOAD: n_state = st_done;
            iee_pkg::S_FINAL: begin
                n_state = (r_err == iee_pkg::ERR_NONE) ? iee_pkg::S_FEED : iee_pkg::S_OUT;
            end
            iee_pkg::S_OUT: begin
                if (out_load) begin
                    n_state = iee_pkg::S_IDLE;
                end
            end
            default: n_state = iee_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_char         = r_char;
        n_last         = r_last;
        n_lv           = r_lv;
        n_ignore       = r_ignore;
        n_err          = r_err;
        n_sum          = r_sum;
        n_term         = r_term;
        n_cur          = r_cur;
        n_neg          = r_neg;
        n_op           = r_op;
        n_kind         = r_kind;
        n_closing      = r_closing;
        n_v            = r_v;
        n_res          = r_res;
        mem_we         = 1'b0;
        alu_req.start  = 1'b0;
        alu_req.is_div = (r_op == iee_pkg::OP_DIV);
        n_out_valid    = r_out_valid && !o_out.ready;
        n_out_value    = r_out_value;
        n_out_err      = r_out_err;
        case (r_state)
            iee_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_char = i_in.character;
                    n_last = i_in.last;
                end
            end
            iee_pkg::S_DECODE: begin
                if (!skip) begin
                    if (is_digit) begin
                        n_cur = cur_x10;
                    end else if (is_lp) begin
                        if (lv_full) begin
                            n_err = iee_pkg::ERR_DEEP;
                        end else begin
                            mem_we = 1'b1;
                            n_lv   = r_lv + LVL_W'(1);
                            n_sum  = '0;
                            n_term = '0;
                            n_cur  = '0;
                            n_neg  = 1'b0;
                            n_op   = iee_pkg::OP_NONE;
                        end
                    end else if (is_rp) begin
                        if (lv_zero) begin
                            n_ignore = 1'b1;
                        end else begin
                            n_kind    = iee_pkg::K_ADD;
                            n_closing = 1'b1;
                        end
                    end else if (is_op) begin
                        n_kind    = char_kind;
                        n_closing = 1'b0;
                    end else begin
                        n_err = iee_pkg::ERR_BADCH;
                    end
                end
            end
            iee_pkg::S_FEED: begin
                if (div_zero) begin
                    n_err = iee_pkg::ERR_DIV0;
                end else if (r_op == iee_pkg::OP_NONE) begin
                    n_v = r_cur;
                end else begin
                    alu_req.start = 1'b1;
                end
            end
            iee_pkg::S_WAIT: begin
                if (alu_rsp.done) begin
                    n_v = alu_result;
                end
            end
            iee_pkg::S_APPLY: begin
                if ((r_kind == iee_pkg::K_ADD) || (r_kind == iee_pkg::K_SUB)) begin
                    n_sum  = applied_sum;
                    n_res  = applied_sum;
                    n_neg  = (r_kind == iee_pkg::K_SUB);
                    n_op   = iee_pkg::OP_NONE;
                    n_term = '0;
                end else begin
                    n_term = r_v;
                    n_op   = (r_kind == iee_pkg::K_MUL) ? iee_pkg::OP_MUL : iee_pkg::OP_DIV;
                end
                if (!r_closing) begin
                    n_cur = '0;
                end
            end
            iee_pkg::S_LOAD: begin
                n_sum  = r_rdata[3*VW+2 -: VW];
                n_term = r_rdata[2*VW+2 -: VW];
                n_neg  = r_rdata[2];
                n_op   = iee_pkg::t_op'(r_rdata[1:0]);
                n_cur  = r_res;
                n_lv   = r_lv - LVL_W'(1);
            end
            iee_pkg::S_FINAL: begin
                n_kind    = iee_pkg::K_ADD;
                n_closing = 1'b1;
            end
            iee_pkg::S_OUT: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_out_value = (r_err == iee_pkg::ERR_NONE) ? res_ext[OUT_W-1:0] : '0;
                    n_out_err   = r_err;
                    n_lv        = '0;
                    n_ignore    = 1'b0;
                    n_err       = iee_pkg::ERR_NONE;
                    n_sum       = '0;
                    n_term      = '0;
                    n_cur       = '0;
                    n_neg       = 1'b0;
                    n_op        = iee_pkg::OP_NONE;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= iee_pkg::S_IDLE;
            r_lv        <= '0;
            r_ignore    <= 1'b0;
            r_err       <= iee_pkg::ERR_NONE;
            r_sum       <= '0;
            r_term      <= '0;
            r_cur       <= '0;
            r_neg       <= 1'b0;
            r_op        <= iee_pkg::OP_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lv        <= n_lv;
            r_ignore    <= n_ignore;
            r_err       <= n_err;
            r_sum       <= n_sum;
            r_term      <= n_term;
            r_cur       <= n_cur;
            r_neg       <= n_neg;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
        end
        r_char      <= n_char;
        r_last      <= n_last;
        r_kind      <= n_kind;
        r_closing   <= n_closing;
        r_v         <= n_v;
        r_res       <= n_res;
        r_out_value <= n_out_value;
        r_out_err   <= n_out_err;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_lv] <= {r_sum, r_term, r_cur, r_neg, r_op};
        end
        r_rdata <= mem[r_lv - LVL_W'(1)];
    end

    assign i_in.ready       = (r_state == iee_pkg::S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.value      = r_out_value;
    assign o_out.error_code = r_out_err;

`ifndef NO_ASSERTIONS
    a_alu_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_req.start |-> !alu_rsp.busy)
        else $error("shared unit started while busy");

    a_alu_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_rsp.done |-> (r_state == iee_pkg::S_WAIT))
        else $error("shared unit finished outside wait");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lv <= LVL_W'(MAX_DEPTH - 1))
        else $error("nesting level out of range");

    a_error_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.error_code != iee_pkg::ERR_NONE)) |-> (o_out.value == '0))
        else $error("nonzero value with error");
`endif

endmodule
